### sv/kcl_pkg.sv
// Shared types and constants for the keypad combination lock.
`default_nettype none
package kcl_pkg;

  localparam int NUM_KEYS  = 6;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;

  typedef logic [3:0] key_idx_t;
  typedef key_idx_t [NUM_KEYS-1:0] key_set_t;

  // decoded key: 0..15 single key, plus two special codes
  typedef logic [4:0] dec_key_t;
  localparam dec_key_t KEY_NONE  = 5'd16;
  localparam dec_key_t KEY_MULTI = 5'd17;

  typedef enum logic [2:0] {
    REG_RESTART   = 3'd0,
    REG_CODE_ONE  = 3'd1,
    REG_CODE_TWO  = 3'd2,
    REG_CODE_THR  = 3'd3,
    REG_CODE_FOUR = 3'd4,
    REG_CODE_FIVE = 3'd5
  } reg_idx_t;

  localparam key_set_t KEYS_RESET = {4'd5, 4'd4, 4'd2, 4'd1, 4'd0, 4'd14};

  typedef enum logic [3:0] {
    ST_START       = 4'd0,
    ST_WAIT_RESTRT = 4'd1,
    ST_REL_RESTRT  = 4'd2,
    ST_WAIT_ONE    = 4'd3,
    ST_REL_ONE     = 4'd4,
    ST_WAIT_TWO    = 4'd5,
    ST_REL_TWO     = 4'd6,
    ST_WAIT_THREE  = 4'd7,
    ST_REL_THREE   = 4'd8,
    ST_WAIT_FOUR   = 4'd9,
    ST_REL_FOUR    = 4'd10,
    ST_WAIT_FIVE   = 4'd11,
    ST_REL_FIVE    = 4'd12,
    ST_OPEN        = 4'd13
  } lock_stage_t;

  // classified item passed from front to back
  typedef struct packed {
    dec_key_t key;
    logic     relock;
  } kcl_item_t;

endpackage
`default_nettype wire

### sv/kcl_regs.sv
// APB register file holding the restart key and the five code keys.
`default_nettype none
module kcl_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [kcl_pkg::CFG_AW-1:0] paddr,
  input  wire logic [kcl_pkg::CFG_DW-1:0] pwdata,
  output logic      [kcl_pkg::CFG_DW-1:0] prdata,
  output logic                           pready,
  output kcl_pkg::key_set_t              keys
);
  import kcl_pkg::*;

  key_set_t keys_r, keys_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign keys   = keys_r;

  always_comb begin
    keys_nxt = keys_r;
    if (wr_en) begin
      case (idx)
        REG_RESTART:   keys_nxt[0] = pwdata[3:0];
        REG_CODE_ONE:  keys_nxt[1] = pwdata[3:0];
        REG_CODE_TWO:  keys_nxt[2] = pwdata[3:0];
        REG_CODE_THR:  keys_nxt[3] = pwdata[3:0];
        REG_CODE_FOUR: keys_nxt[4] = pwdata[3:0];
        REG_CODE_FIVE: keys_nxt[5] = pwdata[3:0];
        default:       keys_nxt = keys_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RESTART:   prdata = {28'd0, keys_r[0]};
      REG_CODE_ONE:  prdata = {28'd0, keys_r[1]};
      REG_CODE_TWO:  prdata = {28'd0, keys_r[2]};
      REG_CODE_THR:  prdata = {28'd0, keys_r[3]};
      REG_CODE_FOUR: prdata = {28'd0, keys_r[4]};
      REG_CODE_FIVE: prdata = {28'd0, keys_r[5]};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= KEYS_RESET;
    end else begin
      keys_r <= keys_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/kcl_front.sv
// Front end: accepts keypad scan items and decodes them to a single key code.
`default_nettype none
module kcl_front (
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_pressed_keys,
  input  wire logic        in_relock_request,
  output logic             push,
  output kcl_pkg::kcl_item_t push_item,
  input  wire logic        q_full
);
  import kcl_pkg::*;

  logic [3:0] enc;
  logic       none, single;

  // OR encoder is exact when one bit is set
  always_comb begin
    enc = '0;
    for (int b = 0; b < 4; b++) begin
      for (int i = 0; i < 16; i++) begin
        if (((i >> b) & 1) == 1) enc[b] = enc[b] | in_pressed_keys[i];
      end
    end
  end

  assign none   = (in_pressed_keys == 16'd0);
  assign single = ((in_pressed_keys & (in_pressed_keys - 16'd1)) == 16'd0);

  always_comb begin
    if (none)        push_item.key = KEY_NONE;
    else if (single) push_item.key = {1'b0, enc};
    else             push_item.key = KEY_MULTI;
    push_item.relock = in_relock_request;
  end

  assign in_stall = q_full;
  assign push     = in_valid & ~q_full;

endmodule
`default_nettype wire

### sv/kcl_queue.sv
// Two-entry queue between the decode front end and the lock back end.
`default_nettype none
module kcl_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire kcl_pkg::kcl_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    q_valid,
  output kcl_pkg::kcl_item_t      q_item
);
  import kcl_pkg::*;

  kcl_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/kcl_back.sv
// Back end: lock state machine and registered result stage.
`default_nettype none
module kcl_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire kcl_pkg::key_set_t  keys,
  input  wire logic               q_valid,
  input  wire kcl_pkg::kcl_item_t q_item,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_is_unlocked,
  output logic [4:0]              out_decoded_key,
  output logic [3:0]              out_lock_step
);
  import kcl_pkg::*;

  lock_stage_t stage_r, stage_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        unl_r;
  dec_key_t    key_r;
  lock_stage_t step_r;
  logic [3:0]  sm1;
  logic [2:0]  exp_idx;
  key_idx_t    exp_key;
  lock_stage_t calc;
  logic        hit_exp, hit_rst, hit_none;

  assign pop           = q_valid & (~out_valid_r | ~out_stall);
  assign out_valid_nxt = pop | (out_valid_r & out_stall);

  assign sm1      = stage_r - 4'd1;
  assign exp_idx  = sm1[3:1];
  assign exp_key  = (exp_idx < 3'd6) ? keys[exp_idx] : keys[0];
  assign hit_exp  = (q_item.key == {1'b0, exp_key});
  assign hit_rst  = (q_item.key == {1'b0, keys[0]});
  assign hit_none = (q_item.key == KEY_NONE);

  always_comb begin
    case (stage_r)
      ST_START:       calc = ST_WAIT_RESTRT;
      ST_OPEN:        calc = q_item.relock ? ST_WAIT_RESTRT : ST_OPEN;
      ST_WAIT_RESTRT: calc = hit_exp ? ST_REL_RESTRT : ST_WAIT_RESTRT;
      ST_WAIT_ONE, ST_WAIT_TWO, ST_WAIT_THREE, ST_WAIT_FOUR, ST_WAIT_FIVE: begin
        if (hit_exp)       calc = lock_stage_t'(stage_r + 4'd1);
        else if (hit_rst)  calc = ST_REL_RESTRT;
        else if (hit_none) calc = stage_r;
        else               calc = ST_WAIT_RESTRT;
      end
      ST_REL_RESTRT, ST_REL_ONE, ST_REL_TWO, ST_REL_THREE, ST_REL_FOUR,
      ST_REL_FIVE: begin
        if (hit_exp)       calc = stage_r;
        else if (hit_none) calc = lock_stage_t'(stage_r + 4'd1);
        else               calc = ST_WAIT_RESTRT;
      end
      default:        calc = ST_WAIT_RESTRT;
    endcase
    stage_nxt = pop ? calc : stage_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= ST_START;
      out_valid_r <= 1'b0;
    end else begin
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      unl_r  <= (calc == ST_OPEN);
      key_r  <= q_item.key;
      step_r <= calc;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_unlocked = unl_r;
  assign out_decoded_key = key_r;
  assign out_lock_step   = step_r;

endmodule
`default_nettype wire

### sv/keypad_combination_lock_core.sv
// Top level: keypad combination lock with decode front end, queue and lock back end.
// An accepted item is written into the queue and, once popped, its result is
// registered. Decode is combinational; queue and result stage are registers.
// Throughput: one item per cycle while out_stall is low. The two-entry queue takes
// two items while a result waits on out_stall, then in_stall rises.
// Reset (rst_n low, synchronous): lock goes to the start state, queue and result
// stage empty, key registers return to restart key 14 and code keys 0,1,2,4,5.
`default_nettype none
module keypad_combination_lock_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_pressed_keys,
  input  wire logic        in_relock_request,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_unlocked,
  output logic [4:0]       out_decoded_key,
  output logic [3:0]       out_lock_step,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [kcl_pkg::CFG_AW-1:0] paddr,
  input  wire logic [kcl_pkg::CFG_DW-1:0] pwdata,
  output logic      [kcl_pkg::CFG_DW-1:0] prdata,
  output logic             pready
);
  import kcl_pkg::*;

  key_set_t  keys;
  kcl_item_t push_item, q_item;
  logic      push, q_full, pop, q_valid;

  kcl_regs u_regs (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .keys(keys)
  );

  kcl_front u_front (
    .in_valid(in_valid), .in_stall(in_stall), .in_pressed_keys(in_pressed_keys),
    .in_relock_request(in_relock_request), .push(push), .push_item(push_item),
    .q_full(q_full)
  );

  kcl_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item), .full(q_full),
    .pop(pop), .q_valid(q_valid), .q_item(q_item)
  );

  kcl_back u_back (
    .clk(clk), .rst_n(rst_n), .keys(keys), .q_valid(q_valid), .q_item(q_item),
    .pop(pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_is_unlocked(out_is_unlocked), .out_decoded_key(out_decoded_key),
    .out_lock_step(out_lock_step)
  );

endmodule
`default_nettype wire
